[src/phtp_pkg.sv]
// shared types, constants and functions of the pes header timestamp parser
package phtp_pkg;

  // byte positions within the pes header
  localparam int unsigned CntW       = 9;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [CntW-1:0] IdxLenHi   = 9'd4;
  localparam logic [CntW-1:0] IdxLenLo   = 9'd5;
  localparam logic [CntW-1:0] IdxFlags   = 9'd7;
  localparam logic [CntW-1:0] IdxHdrLen  = 9'd8;
  localparam logic [CntW-1:0] IdxPtsFirst = 9'd9;
  localparam logic [CntW-1:0] IdxPtsLast  = 9'd13;
  localparam logic [CntW-1:0] IdxDtsFirst = 9'd14;
  localparam logic [CntW-1:0] IdxDtsLast  = 9'd18;

  // byte counts a buffer needs before its result is settled
  localparam logic [CntW-1:0] FixedHdrLen = 9'd9;
  localparam logic [4:0] NeedPtsDts = 5'd19;
  localparam logic [4:0] NeedPts    = 5'd14;
  localparam logic [4:0] NeedNone   = 5'd9;

  // flag masks and stamp byte masks
  localparam logic [7:0] FlagsPtsDts = 8'hC0;
  localparam logic [7:0] FlagsPts    = 8'h80;
  localparam logic [7:0] StampMaskHi = 8'h0E;
  localparam logic [7:0] StampMaskMk = 8'hFE;

  // reciprocal of 45 for a 32-bit dividend: floor(x * Div45Mul / 2^Div45Shift)
  localparam int unsigned Div45Shift = 38;
  localparam logic [32:0] Div45Mul   = 33'h1_6C16_C16D;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT_FIXED = 3'd1,
    ST_SHORT_OPT   = 3'd2,
    ST_SHORT_BOTH  = 3'd3,
    ST_SHORT_PTS   = 3'd4,
    ST_NO_PTS      = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_last;
  } in_beat_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] pes_length;
    logic [26:0] pts_ms;
    logic [26:0] dts_ms;
    logic [8:0]  payload_offset;
  } out_beat_t;

  // settled result before the divide by 45
  typedef struct packed {
    status_e     status;
    logic [15:0] pes_length;
    logic [8:0]  payload_offset;
    logic [31:0] pts_raw;
    logic [31:0] dts_raw;
  } emit_t;

  // contribution of stamp byte k to the top 32 bits of a 33-bit stamp
  function automatic logic [31:0] stamp_part(input logic [2:0] k, input logic [7:0] b);
    logic [31:0] r;
    r = '0;
    case (k)
      3'd0:    r = {4'(b & StampMaskHi), 28'd0};
      3'd1:    r = {3'd0, b, 21'd0};
      3'd2:    r = {11'd0, (b & StampMaskMk), 13'd0};
      3'd3:    r = {18'd0, b, 6'd0};
      3'd4:    r = {26'd0, 6'((b & StampMaskMk) >> 2)};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[src/pes_header_timestamp_parser_top.sv]
// top level of the pes header timestamp parser
// Takes one byte per beat of a buffer that starts at a PES start code, with
// buffer_last on its final byte, and gives one result per buffer: status,
// packet length, PTS and DTS in milliseconds and the payload offset. A byte is
// accepted every cycle while the output keeps up. A result appears after the
// byte that settles it (or the last byte of a short buffer), passing first
// through the parser's settled-result register and then through the
// reciprocal multiply by 1/45 into the output register. Bytes after a settled
// result are consumed without effect up to the last-byte mark, which clears
// all parser state for the next buffer.
module pes_header_timestamp_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  phtp_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output phtp_pkg::out_beat_t out_data_o
);

  logic            em_valid;
  logic            em_ready;
  phtp_pkg::emit_t em_data;

  // header capture and settling
  phtp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .em_valid_o (em_valid),
    .em_ready_i (em_ready),
    .em_data_o  (em_data)
  );

  // stamp conversion to milliseconds
  phtp_div45 u_div45 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .em_valid_i  (em_valid),
    .em_ready_o  (em_ready),
    .em_data_i   (em_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/phtp_parser.sv]
// byte-wise header capture and settling logic with the settled-result register
module phtp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  phtp_pkg::in_beat_t in_data_i,
  output logic               em_valid_o,
  input  logic               em_ready_i,
  output phtp_pkg::emit_t    em_data_o
);

  logic [phtp_pkg::CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [15:0] len_q, len_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  hlen_q, hlen_d;
  logic [31:0] pts_q, pts_d;
  logic [31:0] dts_q, dts_d;
  logic        done_q, done_d;

  logic [phtp_pkg::CntW-1:0] need;
  logic [4:0]  req;
  logic        settle;
  logic        have_times;
  logic        dts_flag;
  logic        emit;
  logic        acc;
  phtp_pkg::emit_t rec;
  phtp_pkg::status_e st;

  logic            em_valid_q;
  phtp_pkg::emit_t em_data_q;

  // a beat enters when the result register is free or draining
  assign in_ready_o = !em_valid_q || em_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  // next state for one byte
  always_comb begin
    cnt_d      = cnt_q;
    len_d      = len_q;
    flags_d    = flags_q;
    hlen_d     = hlen_q;
    pts_d      = pts_q;
    dts_d      = dts_q;
    done_d     = done_q;
    emit       = 1'b0;
    st         = phtp_pkg::ST_OK;
    have_times = 1'b0;
    cnt_inc    = (cnt_q == phtp_pkg::CntMax) ? cnt_q : cnt_q + 1'b1;

    if (!done_q) begin
      // field capture by byte position
      if (cnt_q == phtp_pkg::IdxLenHi) begin
        len_d[15:8] = in_data_i.data_byte;
      end else if (cnt_q == phtp_pkg::IdxLenLo) begin
        len_d[7:0] = in_data_i.data_byte;
      end else if (cnt_q == phtp_pkg::IdxFlags) begin
        flags_d = in_data_i.data_byte;
      end else if (cnt_q == phtp_pkg::IdxHdrLen) begin
        hlen_d = in_data_i.data_byte;
      end else if (cnt_q >= phtp_pkg::IdxPtsFirst && cnt_q <= phtp_pkg::IdxPtsLast) begin
        pts_d = pts_q | phtp_pkg::stamp_part(3'(cnt_q - phtp_pkg::IdxPtsFirst),
                                             in_data_i.data_byte);
      end else if (cnt_q >= phtp_pkg::IdxDtsFirst && cnt_q <= phtp_pkg::IdxDtsLast) begin
        dts_d = dts_q | phtp_pkg::stamp_part(3'(cnt_q - phtp_pkg::IdxDtsFirst),
                                             in_data_i.data_byte);
      end
      cnt_d = cnt_inc;
    end

    // settling bounds from the updated fields
    need     = phtp_pkg::FixedHdrLen + {1'b0, hlen_d};
    dts_flag = (flags_d & phtp_pkg::FlagsPtsDts) == phtp_pkg::FlagsPtsDts;
    if (dts_flag) begin
      req = phtp_pkg::NeedPtsDts;
    end else if ((flags_d & phtp_pkg::FlagsPts) != 8'd0) begin
      req = phtp_pkg::NeedPts;
    end else begin
      req = phtp_pkg::NeedNone;
    end
    settle = (cnt_d >= phtp_pkg::FixedHdrLen) && (cnt_d >= need)
          && (cnt_d >= {4'd0, req});

    if (!done_q) begin
      if (settle) begin
        emit       = 1'b1;
        done_d     = 1'b1;
        have_times = (req != phtp_pkg::NeedNone);
        st         = have_times ? phtp_pkg::ST_OK : phtp_pkg::ST_NO_PTS;
      end else if (in_data_i.buffer_last) begin
        emit = 1'b1;
        if (cnt_d < phtp_pkg::FixedHdrLen) begin
          st = phtp_pkg::ST_SHORT_FIXED;
        end else if (cnt_d < need) begin
          st = phtp_pkg::ST_SHORT_OPT;
        end else if (req == phtp_pkg::NeedPtsDts) begin
          st = phtp_pkg::ST_SHORT_BOTH;
        end else begin
          st = phtp_pkg::ST_SHORT_PTS;
        end
      end
    end

    // settled result, stamps zeroed where not valid
    rec.status         = st;
    rec.pes_length     = (st == phtp_pkg::ST_SHORT_FIXED) ? 16'd0 : len_d;
    rec.payload_offset = (st == phtp_pkg::ST_SHORT_FIXED) ? phtp_pkg::FixedHdrLen : need;
    rec.pts_raw        = have_times ? pts_d : 32'd0;
    rec.dts_raw        = have_times ? (dts_flag ? dts_d : pts_d) : 32'd0;

    // every last byte starts the next buffer from scratch
    if (in_data_i.buffer_last) begin
      cnt_d   = '0;
      len_d   = '0;
      flags_d = '0;
      hlen_d  = '0;
      pts_d   = '0;
      dts_d   = '0;
      done_d  = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      len_q   <= '0;
      flags_q <= '0;
      hlen_q  <= '0;
      pts_q   <= '0;
      dts_q   <= '0;
      done_q  <= 1'b0;
    end else if (acc) begin
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      flags_q <= flags_d;
      hlen_q  <= hlen_d;
      pts_q   <= pts_d;
      dts_q   <= dts_d;
      done_q  <= done_d;
    end
  end

  // settled-result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_valid_q <= 1'b0;
    end else begin
      if (em_valid_q && em_ready_i) em_valid_q <= 1'b0;
      if (acc) em_valid_q <= emit;
    end
  end

  // settled-result payload
  always_ff @(posedge clk_i) begin
    if (acc && emit) em_data_q <= rec;
  end

  assign em_valid_o = em_valid_q;
  assign em_data_o  = em_data_q;

  // once settled, the count has covered the fixed header
  a_done_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> cnt_q >= phtp_pkg::FixedHdrLen)
    else $error("done set before fixed header complete");

  // the count only moves up within a buffer
  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !in_data_i.buffer_last |=> cnt_q >= $past(cnt_q))
    else $error("byte count went down within a buffer");

  // a short fixed header carries no length and the base offset
  a_short_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_valid_q && em_data_q.status == phtp_pkg::ST_SHORT_FIXED
      |-> em_data_q.pes_length == 16'd0
       && em_data_q.payload_offset == phtp_pkg::FixedHdrLen)
    else $error("short fixed header result carries captured fields");

endmodule

[src/phtp_div45.sv]
// divide-by-45 stage for both stamps, feeding the result register
module phtp_div45 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                em_valid_i,
  output logic                em_ready_o,
  input  phtp_pkg::emit_t     em_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output phtp_pkg::out_beat_t out_data_o
);

  logic [64:0] pts_prod;
  logic [64:0] dts_prod;
  logic        load;

  logic                out_valid_q;
  phtp_pkg::out_beat_t out_data_q;

  assign em_ready_o = !out_valid_q || out_ready_i;
  assign load       = em_valid_i && em_ready_o;

  // reciprocal multiply, exact for every 32-bit dividend
  assign pts_prod = {33'd0, em_data_i.pts_raw} * {32'd0, phtp_pkg::Div45Mul};
  assign dts_prod = {33'd0, em_data_i.dts_raw} * {32'd0, phtp_pkg::Div45Mul};

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (load) out_valid_q <= 1'b1;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q.status         <= em_data_i.status;
      out_data_q.pes_length     <= em_data_i.pes_length;
      out_data_q.payload_offset <= em_data_i.payload_offset;
      out_data_q.pts_ms         <= pts_prod[phtp_pkg::Div45Shift +: 27];
      out_data_q.dts_ms         <= dts_prod[phtp_pkg::Div45Shift +: 27];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // stamps are only reported for a settled ok result
  a_stamps_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.status != phtp_pkg::ST_OK
      |-> out_data_q.pts_ms == 27'd0 && out_data_q.dts_ms == 27'd0)
    else $error("stamps reported on a non-ok result");

endmodule

[tb/tb_pes_header_timestamp_parser_top.sv]
// testbench for the pes header timestamp parser: byte stimulus, timestamp prediction, checks
`timescale 1ns / 1ps

module tb_pes_header_timestamp_parser_top;

  logic                clk       = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  phtp_pkg::in_beat_t  in_data   = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  phtp_pkg::out_beat_t out_data;

  // parser state as the predictor sees it
  logic [8:0]  pp_count;
  logic [15:0] pp_length;
  logic [7:0]  pp_flags;
  logic [7:0]  pp_hdr_len;
  logic [31:0] pp_pts;
  logic [31:0] pp_dts;
  logic        pp_done;

  phtp_pkg::out_beat_t stamp_reports_q[$];
  int        n_mismatch = 0;
  int        bytes_fed  = 0;
  int        hold_req   = 0;
  int        hold_left  = 0;
  bit        calm       = 1'b0;

  pes_header_timestamp_parser_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bits of one stamp byte placed into the top 32 bits of the 33-bit stamp
  function automatic logic [31:0] stamp_bits(input int k, input logic [7:0] b);
    case (k)
      0:       return {b[3:1], 29'd0};
      1:       return {3'd0, b, 21'd0};
      2:       return {11'd0, b[7:1], 14'd0};
      3:       return {18'd0, b, 6'd0};
      default: return {26'd0, b[7:2]};
    endcase
  endfunction

  function automatic void clear_parse();
    pp_count   = '0;
    pp_length  = '0;
    pp_flags   = '0;
    pp_hdr_len = '0;
    pp_pts     = '0;
    pp_dts     = '0;
    pp_done    = 1'b0;
  endfunction

  // report for the current buffer; stamps only on a clean parse
  function automatic phtp_pkg::out_beat_t make_report(input phtp_pkg::status_e st);
    phtp_pkg::out_beat_t r;
    r.status         = st;
    r.pes_length     = (st == phtp_pkg::ST_SHORT_FIXED) ? 16'd0 : pp_length;
    r.payload_offset = (st == phtp_pkg::ST_SHORT_FIXED) ? phtp_pkg::FixedHdrLen
                                                        : phtp_pkg::FixedHdrLen + 9'(pp_hdr_len);
    r.pts_ms         = '0;
    r.dts_ms         = '0;
    if (st == phtp_pkg::ST_OK) begin
      r.pts_ms = 27'(pp_pts / 32'd45);
      r.dts_ms = ((pp_flags & phtp_pkg::FlagsPtsDts) == phtp_pkg::FlagsPtsDts)
               ? 27'(pp_dts / 32'd45) : r.pts_ms;
    end
    return r;
  endfunction

  // predict the effect of one accepted byte
  function automatic void parse_pes_byte(input phtp_pkg::in_beat_t beat);
    logic [8:0] pos;
    logic [8:0] need;
    logic [8:0] req;
    phtp_pkg::status_e st;
    pos = pp_count;
    if (pp_done) begin
      if (beat.buffer_last) clear_parse();
      return;
    end
    if (pos == phtp_pkg::IdxLenHi) pp_length[15:8] = beat.data_byte;
    else if (pos == phtp_pkg::IdxLenLo) pp_length[7:0] = beat.data_byte;
    else if (pos == phtp_pkg::IdxFlags) pp_flags = beat.data_byte;
    else if (pos == phtp_pkg::IdxHdrLen) pp_hdr_len = beat.data_byte;
    else if (pos >= phtp_pkg::IdxPtsFirst && pos <= phtp_pkg::IdxPtsLast)
      pp_pts |= stamp_bits(int'(pos - phtp_pkg::IdxPtsFirst), beat.data_byte);
    else if (pos >= phtp_pkg::IdxDtsFirst && pos <= phtp_pkg::IdxDtsLast)
      pp_dts |= stamp_bits(int'(pos - phtp_pkg::IdxDtsFirst), beat.data_byte);
    if (pp_count != phtp_pkg::CntMax) pp_count = pp_count + 9'd1;
    need = phtp_pkg::FixedHdrLen + 9'(pp_hdr_len);
    if ((pp_flags & phtp_pkg::FlagsPtsDts) == phtp_pkg::FlagsPtsDts)
      req = 9'(phtp_pkg::NeedPtsDts);
    else if ((pp_flags & phtp_pkg::FlagsPts) != 8'd0) req = 9'(phtp_pkg::NeedPts);
    else req = 9'(phtp_pkg::NeedNone);
    if (pp_count >= phtp_pkg::FixedHdrLen && pp_count >= need && pp_count >= req) begin
      st = (req == 9'(phtp_pkg::NeedNone)) ? phtp_pkg::ST_NO_PTS : phtp_pkg::ST_OK;
      stamp_reports_q.push_back(make_report(st));
      pp_done = 1'b1;
    end else if (beat.buffer_last) begin
      if (pp_count < phtp_pkg::FixedHdrLen) st = phtp_pkg::ST_SHORT_FIXED;
      else if (pp_count < need) st = phtp_pkg::ST_SHORT_OPT;
      else if (req == 9'(phtp_pkg::NeedPtsDts)) st = phtp_pkg::ST_SHORT_BOTH;
      else st = phtp_pkg::ST_SHORT_PTS;
      stamp_reports_q.push_back(make_report(st));
    end
    if (beat.buffer_last) clear_parse();
  endfunction

  // offer one byte, with an occasional gap before it
  task automatic send_beat(input logic [7:0] b, input logic is_last);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, buffer_last: is_last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_pes_byte(in_data);
    bytes_fed++;
  endtask

  // one pes-shaped buffer; fill >= 0 sets the length bytes and each byte from the stamps on
  task automatic send_pes(input logic [7:0] flags, input logic [7:0] hdr_len,
                          input int total, input int fill);
    logic [7:0] b;
    for (int i = 0; i < total; i++) begin
      b = 8'($urandom);
      case (i)
        0, 1:    b = 8'h00;
        2:       b = 8'h01;
        3:       b = {4'hE, b[3:0]};
        6:       b = {2'b10, b[5:0]};
        7:       b = flags;
        8:       b = hdr_len;
        default: if (fill >= 0) b = 8'(fill);
      endcase
      send_beat(b, i == total - 1);
    end
  endtask

  task automatic send_noise(input int total);
    for (int i = 0; i < total; i++) send_beat(8'($urandom), i == total - 1);
  endtask

  // mostly well-formed packets cut short, cut at settling, or with trailing bytes
  task automatic send_random_pes();
    logic [7:0] f;
    logic [7:0] h;
    int         settle;
    int         total;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_noise($urandom_range(1, 30));
      return;
    end
    f = {2'($urandom_range(3)), 6'($urandom)};
    pick = $urandom_range(99);
    if (pick < 5) h = 8'($urandom);
    else if (pick < 15) h = 8'd0;
    else h = 8'($urandom_range(12));
    if (f[7:6] == 2'b11) settle = phtp_pkg::NeedPtsDts;
    else if (f[7]) settle = phtp_pkg::NeedPts;
    else settle = phtp_pkg::NeedNone;
    if (9 + h > settle) settle = 9 + h;
    pick = $urandom_range(99);
    if (pick < 25) total = $urandom_range(1, settle - 1);
    else if (pick < 40) total = settle;
    else total = settle + $urandom_range(1, 8);
    send_pes(f, h, total, -1);
  endtask

  // stop offering and let every pending report come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (stamp_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed();
    // too short for the fixed header
    send_pes(8'h00, 8'h00, 3, -1);
    // all flags, longest optional header, cut short
    send_pes(8'hFF, 8'hFF, 10, -1);
    // largest stamps, then bytes that must be ignored
    send_pes(8'hC0, 8'h00, 21, 8'hFF);
    // decode flag alone, last byte on the settling byte
    send_pes(8'h40, 8'h00, 9, -1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_req = 300;
    repeat (8) send_random_pes();
    wait_drained();
  endtask

  task automatic test_calm_stretch();
    calm = 1'b1;
    repeat (12) send_random_pes();
    wait_drained();
    calm = 1'b0;
  endtask

  task automatic test_random_buffers();
    while (bytes_fed < 1750) send_random_pes();
    wait_drained();
  endtask

  // receiver: random stalls plus long requested hold-offs
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      n_mismatch++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // compare each report beat with the oldest prediction
  always @(posedge clk) begin
    phtp_pkg::out_beat_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (stamp_reports_q.size() == 0) begin
        n_mismatch++;
        $display("%0t: report with none pending, got %p", $time, out_data);
      end else begin
        want = stamp_reports_q.pop_front();
        check_field("status", want.status, out_data.status);
        check_field("pes_length", want.pes_length, out_data.pes_length);
        check_field("pts_ms", want.pts_ms, out_data.pts_ms);
        check_field("dts_ms", want.dts_ms, out_data.dts_ms);
        check_field("payload_offset", want.payload_offset, out_data.payload_offset);
      end
    end
  end

  initial begin
    clear_parse();
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_calm_stretch();
    test_random_buffers();
    if (n_mismatch == 0 && stamp_reports_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
src/phtp_pkg.sv
src/phtp_parser.sv
src/phtp_div45.sv
src/pes_header_timestamp_parser_top.sv
tb/tb_pes_header_timestamp_parser_top.sv
